// File: rtl/core/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants of the timestamp to calendar date converter:
// item structs, format codes and reciprocal constants for constant division.
// ----------------------------------------------------------------------------
package tcd_pkg;

    typedef enum logic [1:0] {
        FMT_SEC1980  = 2'd0,
        FMT_IEC61850 = 2'd1,
        FMT_USEC     = 2'd2,
        FMT_SEC1970  = 2'd3
    } t_func;

    typedef struct packed {
        logic [63:0] raw_time;
        t_func       func;
    } t_in_item;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
    } t_out_item;

    localparam logic [31:0] EPOCH_DELTA = 32'd315532800;

    // reciprocal multipliers, x / d == (x * MUL) >> SH over the needed range
    localparam int          USEC_DIV_SH  = 38;
    localparam logic [28:0] USEC_DIV_MUL =
        29'(((64'd1 << USEC_DIV_SH) + 64'd999) / 64'd1000);

    localparam int          DIV60_SH  = 37;
    localparam logic [31:0] DIV60_MUL =
        32'(((64'd1 << DIV60_SH) + 64'd59) / 64'd60);

    localparam int          MS_DIV_SH  = 26;
    localparam logic [16:0] MS_DIV_MUL =
        17'(((64'd1 << MS_DIV_SH) + 64'd999) / 64'd1000);

    localparam int DATE_LAT   = 5;
    localparam int PIPE_DEPTH = 3 + DATE_LAT;

endpackage

// File: rtl/core/tcd_date.sv
// ----------------------------------------------------------------------------
// tcd_date
// Pipelined split of an hour count since 1980-01-01 into year, month, day
// and hour of day. Every fourth year from 1980 is a leap year.
// ----------------------------------------------------------------------------
module tcd_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [20:0] i_hours,
    output logic        o_valid,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour
);
    import tcd_pkg::*;

    localparam int          QUAD_SH  = 36;
    localparam logic [20:0] QUAD_MUL =
        21'(((64'd1 << QUAD_SH) + 64'd35063) / 64'd35064);
    localparam int          DAY_SH  = 19;
    localparam logic [14:0] DAY_MUL =
        15'(((64'd1 << DAY_SH) + 64'd23) / 64'd24);

    localparam logic [20:0] HOURS_PER_QUAD = 21'd35064;
    localparam logic [15:0] HOURS_LEAP     = 16'd8784;
    localparam logic [15:0] HOURS_COMMON   = 16'd8760;
    localparam logic [15:0] HOURS_COMMON2  = 16'd17520;

    localparam logic [8:0] MONTH_END [0:10] =
        '{9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

    logic [DATE_LAT-1:0] r_v;

    logic [20:0] r1_hours;
    logic [5:0]  r1_quad;
    logic [15:0] r2_rem;
    logic [5:0]  r2_quad;
    logic [13:0] r3_t;
    logic [11:0] r3_year;
    logic [13:0] r4_t;
    logic [8:0]  r4_dq;
    logic [11:0] r4_year;

    logic [41:0] w_pquad;
    logic [28:0] w_pday;
    logic [15:0] w_t2;
    logic [13:0] n_t;
    logic [1:0]  n_yoff;
    logic [8:0]  w_doy;
    logic [8:0]  w_d;
    logic [8:0]  w_start;
    logic [3:0]  n_month;
    logic [4:0]  n_day;
    logic        w_leap;

    assign w_pquad = 42'(i_hours) * 42'(QUAD_MUL);
    assign w_pday  = 29'(r3_t) * 29'(DAY_MUL);
    assign w_t2    = r2_rem - HOURS_LEAP;

    always_comb begin
        if (r2_rem < HOURS_LEAP) begin
            n_yoff = 2'd0;
            n_t    = 14'(r2_rem);
        end else if (w_t2 >= HOURS_COMMON2) begin
            n_yoff = 2'd3;
            n_t    = 14'(w_t2 - HOURS_COMMON2);
        end else if (w_t2 >= HOURS_COMMON) begin
            n_yoff = 2'd2;
            n_t    = 14'(w_t2 - HOURS_COMMON);
        end else begin
            n_yoff = 2'd1;
            n_t    = 14'(w_t2);
        end
    end

    assign w_leap = (r4_year[1:0] == 2'd0);
    assign w_doy  = r4_dq + 9'd1;
    assign w_d    = (w_leap && w_doy > 9'd60) ? w_doy - 9'd1 : w_doy;

    always_comb begin
        n_month = 4'd1;
        w_start = 9'd0;
        for (int m = 0; m < 11; m++) begin
            if (MONTH_END[m] < w_d) begin
                n_month = 4'(m + 2);
                w_start = MONTH_END[m];
            end
        end
        n_day = 5'(w_d - w_start);
        if (w_leap && w_doy == 9'd60) begin
            n_month = 4'd2;
            n_day   = 5'd29;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DATE_LAT-2:0], i_valid};
        end

        r1_hours <= i_hours;
        r1_quad  <= w_pquad[QUAD_SH +: 6];

        r2_rem  <= 16'(r1_hours - 21'(r1_quad) * HOURS_PER_QUAD);
        r2_quad <= r1_quad;

        r3_t    <= n_t;
        r3_year <= 12'd1980 + {4'd0, r2_quad, 2'b00} + 12'(n_yoff);

        r4_t    <= r3_t;
        r4_dq   <= w_pday[DAY_SH +: 9];
        r4_year <= r3_year;

        o_hour  <= 5'(r4_t - 14'(r4_dq) * 14'd24);
        o_year  <= r4_year;
        o_month <= n_month;
        o_day   <= n_day;
    end

    assign o_valid = r_v[DATE_LAT-1];

endmodule

// File: rtl/core/timestamp_to_calendar_date.sv
// ----------------------------------------------------------------------------
// timestamp_to_calendar_date
// Throughput: one item per cycle, o_busy stays low; every stage is one
// multiply by a reciprocal constant or one subtract and compare chain.
// Reset: synchronous active low, clears all stage valid bits; items in
// flight are dropped. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module timestamp_to_calendar_date (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tcd_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_done,
    output tcd_pkg::t_out_item o_result
);
    import tcd_pkg::*;

    typedef struct packed {
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] ms;
    } t_side;

    logic        w_accept;
    logic [31:0] w_frac;
    logic [41:0] w_piec;
    logic [60:0] w_pusec;
    logic [31:0] n_secs;
    logic [15:0] n_ms16;
    logic [63:0] w_p60;
    logic [32:0] w_pms;
    logic [58:0] w_ph;

    logic        r1_v;
    logic [31:0] r1_secs;
    logic [15:0] r1_ms16;
    logic        r2_v;
    logic [31:0] r2_secs;
    logic [26:0] r2_q60;
    logic [15:0] r2_ms16;
    logic [6:0]  r2_qms;
    logic        r3_v;
    logic [26:0] r3_q60;
    logic [5:0]  r3_sec;
    logic [9:0]  r3_ms;
    logic [20:0] r3_hours;

    t_side       r_side [DATE_LAT];
    t_side       n_side;

    logic        w_date_v;
    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic [4:0]  w_hour;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    assign w_frac  = i_item.raw_time[31:0];
    assign w_piec  = 42'(w_frac) * 42'd1000;
    assign w_pusec = 61'(w_frac) * 61'(USEC_DIV_MUL);

    always_comb begin
        unique case (i_item.func)
            FMT_SEC1980: begin
                n_secs = i_item.raw_time[47:16];
                n_ms16 = i_item.raw_time[15:0];
            end
            FMT_IEC61850: begin
                n_secs = i_item.raw_time[63:32] - EPOCH_DELTA;
                n_ms16 = {6'd0, w_piec[41:32]};
            end
            FMT_USEC: begin
                n_secs = i_item.raw_time[63:32] - EPOCH_DELTA;
                n_ms16 = w_pusec[USEC_DIV_SH +: 16];
            end
            default: begin
                n_secs = i_item.raw_time[31:0] - EPOCH_DELTA;
                n_ms16 = 16'd0;
            end
        endcase
    end

    assign w_p60 = 64'(r1_secs) * 64'(DIV60_MUL);
    assign w_pms = 33'(r1_ms16) * 33'(MS_DIV_MUL);
    assign w_ph  = 59'(r2_q60) * 59'(DIV60_MUL);

    assign n_side.minute = 6'(r3_q60 - 27'(r3_hours) * 27'd60);
    assign n_side.second = r3_sec;
    assign n_side.ms     = r3_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= w_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end

        r1_secs <= n_secs;
        r1_ms16 <= n_ms16;

        r2_secs <= r1_secs;
        r2_q60  <= w_p60[DIV60_SH +: 27];
        r2_ms16 <= r1_ms16;
        r2_qms  <= w_pms[MS_DIV_SH +: 7];

        r3_q60   <= r2_q60;
        r3_sec   <= 6'(r2_secs - 32'(r2_q60) * 32'd60);
        r3_ms    <= 10'(r2_ms16 - 16'(r2_qms) * 16'd1000);
        r3_hours <= w_ph[DIV60_SH +: 21];

        r_side[0] <= n_side;
        for (int k = 1; k < DATE_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    tcd_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_hours (r3_hours),
        .o_valid (w_date_v),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day),
        .o_hour  (w_hour)
    );

    assign o_done               = w_date_v;
    assign o_result.year        = w_year;
    assign o_result.month       = w_month;
    assign o_result.day         = w_day;
    assign o_result.hour        = w_hour;
    assign o_result.minute      = r_side[DATE_LAT-1].minute;
    assign o_result.second      = r_side[DATE_LAT-1].second;
    assign o_result.millisecond = r_side[DATE_LAT-1].ms;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##PIPE_DEPTH o_done)
        else $error("item did not leave the pipeline on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, PIPE_DEPTH))
        else $error("result without a matching item");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.millisecond < 10'd1000) && (o_result.second < 6'd60)
                   && (o_result.minute < 6'd60) && (o_result.hour < 5'd24))
        else $error("time of day field out of range");

    a_feb_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.month == 4'd2) |->
            (o_result.day <= 5'd29) && (o_result.day != 5'd0)
            && (o_result.day != 5'd29 || o_result.year[1:0] == 2'd0))
        else $error("bad february day");

endmodule

// File: verif/tb_timestamp_to_calendar_date.sv
// ----------------------------------------------------------------------------
// tb_timestamp_to_calendar_date
// Self-checking testbench for the timestamp to calendar date converter.
// A directed set of corner timestamps in all four formats comes first.
// Fully random raw values follow, then timestamps placed on day, year and
// leap day edges, then a back to back stream. Every item is predicted when
// it is accepted, and each strobed result is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timestamp_to_calendar_date;

    import tcd_pkg::*;

    localparam logic [31:0] HOURS_PER_QUAD   = 32'd1461 * 32'd24;
    localparam logic [31:0] HOURS_LEAP_YEAR  = 32'd366 * 32'd24;
    localparam logic [31:0] HOURS_COMMON_YR  = 32'd365 * 32'd24;
    localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [31:0] LAST_DAY         = 32'd49710;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_item;
    logic      o_busy;
    logic      o_done;
    t_out_item o_result;

    t_out_item pending_dates [$];
    t_out_item want;
    int        mismatch_count;

    timestamp_to_calendar_date uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_out_item calc_date(input t_in_item it);
        logic [31:0] secs;
        logic [31:0] ms;
        logic [31:0] t;
        logic [31:0] yr;
        logic [31:0] dy;
        logic [31:0] mlen;
        logic [63:0] wide;
        int          m;
        t_out_item   r;
        case (it.func)
            FMT_SEC1980: begin
                secs = it.raw_time[47:16];
                ms   = {16'd0, it.raw_time[15:0]};
            end
            FMT_IEC61850: begin
                secs = it.raw_time[63:32] - EPOCH_DELTA;
                wide = {32'd0, it.raw_time[31:0]} * 64'd1000;
                ms   = wide[63:32];
            end
            FMT_USEC: begin
                secs = it.raw_time[63:32] - EPOCH_DELTA;
                wide = {32'd0, it.raw_time[31:0]} / 64'd1000;
                ms   = {16'd0, wide[15:0]};
            end
            default: begin
                secs = it.raw_time[31:0] - EPOCH_DELTA;
                ms   = 32'd0;
            end
        endcase
        ms = ms % 32'd1000;

        t        = secs;
        r.second = 6'(t % 32'd60);
        t        = t / 32'd60;
        r.minute = 6'(t % 32'd60);
        t        = t / 32'd60;

        yr = 32'd1980 + ((t / HOURS_PER_QUAD) << 2);
        t  = t % HOURS_PER_QUAD;
        if (t >= HOURS_LEAP_YEAR) begin
            t  = t - HOURS_LEAP_YEAR;
            yr = yr + 32'd1 + t / HOURS_COMMON_YR;
            t  = t % HOURS_COMMON_YR;
        end
        r.hour = 5'(t % 32'd24);
        dy     = t / 32'd24 + 32'd1;

        if (yr[1:0] == 2'd0 && dy == 32'd60) begin
            r.month = 4'd2;
            r.day   = 5'd29;
        end else begin
            if (yr[1:0] == 2'd0 && dy > 32'd60)
                dy = dy - 32'd1;
            m    = 0;
            mlen = 32'd31;
            while (m < 11 && mlen < dy) begin
                dy   = dy - mlen;
                m    = m + 1;
                mlen = (m == 1) ? 32'd28 :
                       (m == 3 || m == 5 || m == 8 || m == 10) ? 32'd30 : 32'd31;
            end
            r.month = 4'(m + 1);
            r.day   = 5'(dy);
        end
        r.year        = 12'(yr);
        r.millisecond = 10'(ms);
        return r;
    endfunction

    // place seconds since 1980 into a raw timestamp, filler bits random
    function automatic t_in_item pack_secs(input logic [31:0] secs, input t_func f);
        t_in_item it;
        it.func = f;
        case (f)
            FMT_SEC1980:  it.raw_time = {16'($urandom), secs, 16'($urandom)};
            FMT_IEC61850: it.raw_time = {secs + EPOCH_DELTA, 32'($urandom)};
            FMT_USEC:     it.raw_time = {secs + EPOCH_DELTA, 32'($urandom)};
            default:      it.raw_time = {32'($urandom), secs + EPOCH_DELTA};
        endcase
        return it;
    endfunction

    // seconds on a day edge, a year edge or around a leap day
    function automatic logic [31:0] edge_secs();
        logic [31:0] dnum;
        logic [31:0] ofs;
        logic [31:0] quad;
        quad = $urandom_range(0, 33);
        case ($urandom_range(0, 2))
            0: dnum = $urandom_range(0, LAST_DAY);
            1: dnum = quad * 32'd1461 + $urandom_range(58, 60);
            default: begin
                case ($urandom_range(0, 3))
                    0: dnum = quad * 32'd1461;
                    1: dnum = quad * 32'd1461 + 32'd366;
                    2: dnum = quad * 32'd1461 + 32'd731;
                    default: dnum = quad * 32'd1461 + 32'd1096;
                endcase
                if ($urandom_range(0, 1) == 0 && dnum != 0)
                    dnum = dnum - 32'd1;
            end
        endcase
        case ($urandom_range(0, 3))
            0: ofs = 32'd0;
            1: ofs = SECS_PER_DAY - 32'd1;
            2: ofs = 32'd3600 * $urandom_range(0, 23) + $urandom_range(0, 1);
            default: ofs = $urandom_range(0, 86399);
        endcase
        return dnum * SECS_PER_DAY + ofs;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
    endtask

    task automatic send_item(input t_in_item it);
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        pending_dates.push_back(calc_date(it));
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_dates();
        i_start <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        t_in_item it;
        send_item(pack_secs(32'd0, FMT_SEC1980));
        it.func = FMT_SEC1980; it.raw_time = '1;
        send_item(it);
        it.raw_time = {16'h0000, 32'd1000, 16'd999};
        send_item(it);
        it.raw_time = {16'hffff, 32'd59, 16'd1000};
        send_item(it);
        it.raw_time = {16'h0000, 32'd59 * SECS_PER_DAY + 32'd3661, 16'd0};
        send_item(it);
        it.raw_time = {16'h0000, 32'd60 * SECS_PER_DAY, 16'd0};
        send_item(it);
        it.raw_time = {16'h0000, 32'd366 * SECS_PER_DAY - 32'd1, 16'd0};
        send_item(it);
        it.raw_time = {16'h0000, 32'd366 * SECS_PER_DAY, 16'd0};
        send_item(it);
        it.raw_time = {16'h0000, 32'd43889 * SECS_PER_DAY, 16'd0};
        send_item(it);
        it.func = FMT_IEC61850; it.raw_time = {EPOCH_DELTA, 32'd0};
        send_item(it);
        it.raw_time = {EPOCH_DELTA, 32'hffff_ffff};
        send_item(it);
        it.raw_time = {32'd0, 32'h8000_0000};
        send_item(it);
        it.raw_time = '1;
        send_item(it);
        it.func = FMT_USEC; it.raw_time = {EPOCH_DELTA, 32'd999999};
        send_item(it);
        it.raw_time = {EPOCH_DELTA, 32'hffff_ffff};
        send_item(it);
        it.raw_time = {EPOCH_DELTA + 32'd1, 32'd1000000};
        send_item(it);
        it.raw_time = '0;
        send_item(it);
        it.func = FMT_SEC1970; it.raw_time = {32'hffff_ffff, EPOCH_DELTA};
        send_item(it);
        it.raw_time = '0;
        send_item(it);
        it.raw_time = '1;
        send_item(it);
        it.raw_time = {32'h0, EPOCH_DELTA - 32'd1};
        send_item(it);
        wait_all_dates();
    endtask

    task automatic test_random_raw(input int count);
        t_in_item it;
        int       pct;
        pct = 25;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                pct = 25 * $urandom_range(0, 2);
            it.raw_time = {32'($urandom), 32'($urandom)};
            it.func     = t_func'($urandom_range(0, 3));
            send_item(it);
            sender_gap(pct);
        end
    endtask

    task automatic test_day_edges(input int count);
        int pct;
        pct = 25;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                pct = 25 * $urandom_range(0, 2);
            send_item(pack_secs(edge_secs(), t_func'($urandom_range(0, 3))));
            sender_gap(pct);
            if (n % 250 == 249)
                wait_all_dates();
        end
    endtask

    task automatic test_back_to_back(input int count);
        t_in_item it;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                it.raw_time = {32'($urandom), 32'($urandom)};
                it.func     = t_func'($urandom_range(0, 3));
            end else begin
                it = pack_secs(edge_secs(), t_func'($urandom_range(0, 3)));
            end
            send_item(it);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = pending_dates.pop_front();
                check_field("year", o_result.year, want.year);
                check_field("month", o_result.month, want.month);
                check_field("day", o_result.day, want.day);
                check_field("hour", o_result.hour, want.hour);
                check_field("minute", o_result.minute, want.minute);
                check_field("second", o_result.second, want.second);
                check_field("millisecond", o_result.millisecond, want.millisecond);
            end
        end
    end

    initial begin
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_item         = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_raw(500);
        test_day_edges(700);
        test_back_to_back(400);

        wait_all_dates();
        repeat (2 * PIPE_DEPTH + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
